@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the circular deque.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while out of reset.
`define CDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every rising clock edge while out of reset.
`define CDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cdq_pkg.sv @@
// Shared types and codes for the circular deque.
// Depends on nothing; used by every module of the block.
package cdq_pkg;

  // Default number of entries in the store.
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Width of one stored word.
  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] cdq_word_t;

  // Operation codes carried by an input transfer.
  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_REAR   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } cdq_op_e;

  // Status codes carried by a result transfer.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } cdq_status_e;

  // Memory port controls from the controller.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cdq_mem_ctrl_t;

  // Registered result flags from the controller.
  typedef struct packed {
    logic        valid;
    logic        pop_ok;
    cdq_status_e status;
    logic        now_empty;
    logic        now_full;
  } cdq_res_t;

endpackage

@@ rtl/core/circular_deque_unit.sv @@
// Circular deque of signed 32-bit words: one operation per transfer, one result per
// transfer, strobed by result_valid_o for exactly one cycle, in the cycle after the
// input transfer. busy stays low, so a new operation may be started in every cycle;
// the rate is one item per clock, set by the single port of the entry memory, which
// either writes a pushed word or reads a popped word. The receiver cannot stall and
// must take each result in the cycle it appears. A push on a full deque is rejected
// with overflow status, a pop on an empty deque reports underflow, and popped_value_o
// is zero for every result that is not a successful pop. No clearing pass is needed
// after reset. Depends on cdq_pkg, cdq_ctrl, cdq_mem and assert_macros.svh.
`include "assert_macros.svh"

module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  cdq_pkg::cdq_word_t push_value_i,
  output logic               result_valid_o,
  output cdq_pkg::cdq_word_t popped_value_o,
  output logic [1:0]         status_o,
  output logic               now_empty_o,
  output logic               now_full_o
);
  import cdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  cdq_mem_ctrl_t    mem_ctrl;
  logic [IdxW-1:0]  mem_addr;
  cdq_word_t        mem_rdata;
  cdq_res_t         res;
  logic             accept;

  // No operation needs a wait state, so the block never holds off a start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .mem_ctrl_o  (mem_ctrl),
    .mem_addr_o  (mem_addr),
    .res_o       (res)
  );

  cdq_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (mem_addr),
    .wdata_i (push_value_i),
    .rdata_o (mem_rdata)
  );

  // Result ports; the popped word arrives from the memory read register.
  assign result_valid_o = res.valid;
  assign popped_value_o = res.pop_ok ? mem_rdata : '0;
  assign status_o       = res.status;
  assign now_empty_o    = res.now_empty;
  assign now_full_o     = res.now_full;

  // Every accepted transfer yields a result in the next cycle.
  `CDQ_ASSERT_IMPL(a_result_follows, accept, ##1 result_valid_o, "result missing after start")
  // A deque cannot be empty and full at once.
  `CDQ_ASSERT_IMPL(a_not_empty_and_full, result_valid_o, !(now_empty_o && now_full_o),
                   "deque reported empty and full")
  // A rejected push leaves a full deque.
  `CDQ_ASSERT_IMPL(a_overflow_full, result_valid_o && status_o == ST_OVERFLOW,
                   now_full_o && !now_empty_o, "overflow reported on a deque not full")
  // A pop on an empty deque leaves it empty and returns zero.
  `CDQ_ASSERT_IMPL(a_underflow_empty, result_valid_o && status_o == ST_UNDERFLOW,
                   now_empty_o && popped_value_o == '0, "underflow result inconsistent")

endmodule

@@ rtl/core/cdq_mem.sv @@
// Entry store of the circular deque: one write or one read per cycle.
// Depends on cdq_pkg; read data is registered.
module cdq_mem #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  cdq_pkg::cdq_mem_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]      addr_i,
  input  cdq_pkg::cdq_word_t    wdata_i,
  output cdq_pkg::cdq_word_t    rdata_o
);
  import cdq_pkg::*;

  cdq_word_t mem_q [DEPTH];
  cdq_word_t rdata_q;

  // Synchronous write port; entries have no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Synchronous read port with registered data.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/cdq_ctrl.sv @@
// Index and flag controller of the circular deque.
// Depends on cdq_pkg; drives the port of cdq_mem and the result flags.
module cdq_ctrl #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [1:0]             operation_i,
  output cdq_pkg::cdq_mem_ctrl_t mem_ctrl_o,
  output logic [IDX_W-1:0]       mem_addr_o,
  output cdq_pkg::cdq_res_t      res_o
);
  import cdq_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] rear_q, rear_d;
  logic             empty_q, empty_d;
  cdq_res_t         res_q, res_d;

  logic [IDX_W-1:0] front_next, front_prev, rear_next, rear_prev;
  logic             full_now;
  cdq_op_e          op;

  // Circular neighbors of the current indices.
  assign front_next = (front_q == LastIdx) ? '0 : front_q + 1'b1;
  assign front_prev = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign rear_next  = (rear_q == LastIdx) ? '0 : rear_q + 1'b1;
  assign rear_prev  = (rear_q == '0) ? LastIdx : rear_q - 1'b1;
  assign full_now   = !empty_q && (rear_next == front_q);

  assign op = cdq_op_e'(operation_i);

  // Index update and memory access for an accepted transfer.
  always_comb begin
    front_d    = front_q;
    rear_d     = rear_q;
    empty_d    = empty_q;
    mem_ctrl_o = '0;
    mem_addr_o = front_q;
    res_d      = '0;

    if (accept_i) begin
      res_d.valid  = 1'b1;
      res_d.status = ST_DONE;
      unique case (op)
        OP_PUSH_REAR, OP_PUSH_FRONT: begin
          if (empty_q) begin
            // A push on an empty deque restarts at entry zero.
            front_d          = '0;
            rear_d           = '0;
            empty_d          = 1'b0;
            mem_ctrl_o.wr_en = 1'b1;
            mem_addr_o       = '0;
          end else if (full_now) begin
            res_d.status = ST_OVERFLOW;
          end else if (op == OP_PUSH_REAR) begin
            rear_d           = rear_next;
            mem_ctrl_o.wr_en = 1'b1;
            mem_addr_o       = rear_next;
          end else begin
            front_d          = front_prev;
            mem_ctrl_o.wr_en = 1'b1;
            mem_addr_o       = front_prev;
          end
        end
        OP_POP_REAR, OP_POP_FRONT: begin
          if (empty_q) begin
            res_d.status = ST_UNDERFLOW;
          end else if (front_q == rear_q) begin
            // Removing the last entry empties the deque and rewinds it.
            front_d          = '0;
            rear_d           = '0;
            empty_d          = 1'b1;
            res_d.pop_ok     = 1'b1;
            mem_ctrl_o.rd_en = 1'b1;
            mem_addr_o       = front_q;
          end else if (op == OP_POP_REAR) begin
            rear_d           = rear_prev;
            res_d.pop_ok     = 1'b1;
            mem_ctrl_o.rd_en = 1'b1;
            mem_addr_o       = rear_q;
          end else begin
            front_d          = front_next;
            res_d.pop_ok     = 1'b1;
            mem_ctrl_o.rd_en = 1'b1;
            mem_addr_o       = front_q;
          end
        end
        default: ;
      endcase
    end

    // Flags as they stand after this transfer.
    res_d.now_empty = empty_d;
    res_d.now_full  = !empty_d && (((rear_d == LastIdx) ? '0 : rear_d + 1'b1) == front_d);
  end

  // Deque state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
      res_q   <= '0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ tb/sv/tb_circular_deque_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for circular_deque_unit: directed and random pushes and pops,
// each result checked against a behavioral copy or a pinned value. Depends on cdq_pkg.
module tb_circular_deque_unit;
  import cdq_pkg::*;

  localparam int unsigned DEPTH          = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS   = 1925;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned DRAIN_CYCLES   = 4;

  // Expected contents of one result transfer.
  typedef struct packed {
    cdq_word_t   popped;
    cdq_status_e status;
    logic        empty;
    logic        full;
  } deque_result_t;

  // One row of the directed sequence; repeated pushes store val, val + 1, and so on.
  typedef struct {
    cdq_op_e     op;
    cdq_word_t   val;
    int unsigned reps;
    bit          pinned;
    cdq_word_t   exp_popped;
    cdq_status_e exp_status;
    logic        exp_empty;
    logic        exp_full;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] operation_i;
  cdq_word_t  push_value_i;
  logic       result_valid_o;
  cdq_word_t  popped_value_o;
  logic [1:0] status_o;
  logic       now_empty_o;
  logic       now_full_o;

  // Typed-in expectation that overrides the predicted one for the current transfer.
  bit            pin_valid;
  deque_result_t pin_res;

  deque_result_t pending_results[$];
  int unsigned   err_cnt;
  int unsigned   idle_cycles;
  bit            sender_idles;

  // Shadow copy of the deque state.
  cdq_word_t   shadow_slots [DEPTH];
  int unsigned shadow_front;
  int unsigned shadow_rear;
  bit          shadow_empty;

  circular_deque_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .now_empty_o    (now_empty_o),
    .now_full_o     (now_full_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned step_up(input int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned step_down(input int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  function automatic bit deque_full();
    return !shadow_empty && step_up(shadow_rear) == shadow_front;
  endfunction

  // Applies one operation to the shadow deque and returns the result it produces.
  function automatic deque_result_t deque_apply(input cdq_op_e op, input cdq_word_t word);
    deque_result_t r;
    r.popped = '0;
    r.status = ST_DONE;
    if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
      if (shadow_empty) begin
        // The first entry always lands in slot zero.
        shadow_front    = 0;
        shadow_rear     = 0;
        shadow_slots[0] = word;
        shadow_empty    = 1'b0;
      end else if (deque_full()) begin
        r.status = ST_OVERFLOW;
      end else if (op == OP_PUSH_REAR) begin
        shadow_rear               = step_up(shadow_rear);
        shadow_slots[shadow_rear] = word;
      end else begin
        shadow_front               = step_down(shadow_front);
        shadow_slots[shadow_front] = word;
      end
    end else begin
      if (shadow_empty) begin
        r.status = ST_UNDERFLOW;
      end else if (shadow_front == shadow_rear) begin
        // Removing the last entry returns both indices to zero.
        r.popped     = shadow_slots[shadow_front];
        shadow_front = 0;
        shadow_rear  = 0;
        shadow_empty = 1'b1;
      end else if (op == OP_POP_REAR) begin
        r.popped    = shadow_slots[shadow_rear];
        shadow_rear = step_down(shadow_rear);
      end else begin
        r.popped     = shadow_slots[shadow_front];
        shadow_front = step_up(shadow_front);
      end
    end
    r.empty = shadow_empty;
    r.full  = deque_full();
    return r;
  endfunction

  // Records the expectation of every input transfer, checks every result transfer
  // and watches for a stalled run.
  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        want = deque_apply(cdq_op_e'(operation_i), push_value_i);
        if (pin_valid) want = pin_res;
        pending_results.push_back(want);
      end
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no pending operation");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (popped_value_o !== want.popped) begin
            $error("popped_value: expected %0d, got %0d", want.popped, popped_value_o);
            err_cnt++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_cnt++;
          end
          if (now_empty_o !== want.empty) begin
            $error("now_empty: expected %0b, got %0b", want.empty, now_empty_o);
            err_cnt++;
          end
          if (now_full_o !== want.full) begin
            $error("now_full: expected %0b, got %0b", want.full, now_full_o);
            err_cnt++;
          end
        end
      end
      if ((start && !busy) || result_valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Issues one operation after a random gap if sender_idles is set, optionally after
  // the deque has answered everything in flight, and returns at the edge that accepts it.
  task automatic issue_op(input cdq_op_e op, input cdq_word_t word, input bit hold,
                          input bit pin, input deque_result_t pinned_res);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    if (gap != 0 || hold) begin
      start <= 1'b0;
      if (hold) begin
        do @(negedge clk_i); while (pending_results.size() != 0);
        @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    push_value_i <= word;
    pin_valid    <= pin;
    pin_res      <= pinned_res;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin : stimulus
    stim_row_t     rows[$];
    stim_row_t     row;
    deque_result_t res;
    cdq_op_e       op;
    cdq_word_t     word;
    int unsigned   sent;
    int unsigned   burst;
    int unsigned   push_pct;
    bit            is_push;

    rst_ni       = 1'b0;
    start        <= 1'b0;
    operation_i  <= OP_PUSH_REAR;
    push_value_i <= '0;
    pin_valid    <= 1'b0;
    pin_res      <= '0;
    err_cnt      = 0;
    idle_cycles  = 0;
    sender_idles = 1'b1;
    shadow_front = 0;
    shadow_rear  = 0;
    shadow_empty = 1'b1;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // Underflow from reset, single-entry round trips with extreme words, a fill from
    // both ends, overflow at either end, then pops from the full deque.
    rows.push_back('{OP_POP_REAR, '0, 1, 1'b1, '0, ST_UNDERFLOW, 1'b1, 1'b0});
    rows.push_back('{OP_POP_FRONT, '1, 1, 1'b1, '0, ST_UNDERFLOW, 1'b1, 1'b0});
    rows.push_back('{OP_PUSH_REAR, 32'sh7FFF_FFFF, 1, 1'b1, '0, ST_DONE, 1'b0, 1'b0});
    rows.push_back('{OP_POP_FRONT, '0, 1, 1'b1, 32'sh7FFF_FFFF, ST_DONE, 1'b1, 1'b0});
    rows.push_back('{OP_PUSH_FRONT, 32'sh8000_0000, 1, 1'b1, '0, ST_DONE, 1'b0, 1'b0});
    rows.push_back('{OP_POP_REAR, '0, 1, 1'b1, 32'sh8000_0000, ST_DONE, 1'b1, 1'b0});
    rows.push_back('{OP_PUSH_FRONT, 32'sh5555_0000, DEPTH / 2, 1'b0, '0, ST_DONE, 1'b0,
                     1'b0});
    rows.push_back('{OP_PUSH_REAR, 32'shAAAA_FFF0, DEPTH - DEPTH / 2, 1'b0, '0, ST_DONE,
                     1'b0, 1'b0});
    rows.push_back('{OP_PUSH_REAR, '1, 1, 1'b1, '0, ST_OVERFLOW, 1'b0, 1'b1});
    rows.push_back('{OP_PUSH_FRONT, '0, 1, 1'b1, '0, ST_OVERFLOW, 1'b0, 1'b1});
    rows.push_back('{OP_POP_FRONT, '0, 1, 1'b0, '0, ST_DONE, 1'b0, 1'b0});
    rows.push_back('{OP_POP_REAR, '0, 1, 1'b0, '0, ST_DONE, 1'b0, 1'b0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence.
    foreach (rows[i]) begin
      row = rows[i];
      res = '{row.exp_popped, row.exp_status, row.exp_empty, row.exp_full};
      for (int unsigned k = 0; k < row.reps; k++) begin
        issue_op(row.op, row.val + cdq_word_t'(k), 1'b0, row.pinned, res);
      end
    end

    // Random bursts, each leaning toward pushes, toward pops or neither, so that the deque
    // keeps running between empty and full, with idling switched on or off per burst.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 25;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(8, 48);
      for (int unsigned k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        is_push = ($urandom_range(0, 99) < push_pct);
        if (is_push) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        end
        case ($urandom_range(0, 9))
          0:       word = 32'sh7FFF_FFFF;
          1:       word = 32'sh8000_0000;
          2:       word = '0;
          3:       word = '1;
          default: word = $urandom();
        endcase
        issue_op(op, word, (sent == RANDOM_ITEMS / 2) || ($urandom_range(0, 49) == 0),
                 1'b0, '0);
        sent++;
      end
    end

    // Let every outstanding result arrive, then keep watching for stray results.
    start <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
